>>> sv/ridwt_pkg.sv
// ----------------------------------------------------------------------------
// Reply ID window tracker package
// Shared widths, cell control and cell status types for the window cell row.
// ----------------------------------------------------------------------------
package ridwt_pkg;

    localparam int ID_W          = 32;
    localparam int COUNT_OUT_W   = 5;
    localparam int WINDOW_DEPTH_DEF = 16;

    // Operation applied by every cell of the row in the same cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_SHL
    } t_cell_op;

    // Broadcast control to all cells
    typedef struct packed {
        t_cell_op          op;
        logic [ID_W-1:0]   id;
    } t_cell_ctrl;

    // Status one cell shows to its neighbors and to the control
    typedef struct packed {
        logic [ID_W-1:0]   value;
        logic              valid;
        logic              gt;
        logic              eq;
    } t_cell_out;

    // Stand-in neighbor to the left of the front cell: valid, never greater
    localparam t_cell_out CELL_HEAD = '{value: '0, valid: 1'b1, gt: 1'b0, eq: 1'b0};
    // Stand-in neighbor to the right of the last cell: empty
    localparam t_cell_out CELL_NONE = '{value: '0, valid: 1'b0, gt: 1'b0, eq: 1'b0};

endpackage

>>> sv/ridwt_cell.sv
// ----------------------------------------------------------------------------
// Reply ID window cell
// Holds one window entry; compares it against the broadcast ID, shifts right
// to open a slot for an ordered insert, or shifts left to drop the front.
// ----------------------------------------------------------------------------
module ridwt_cell
    import ridwt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctrl  i_ctrl,
    input  t_cell_out   i_left,
    input  t_cell_out   i_right,
    output t_cell_out   o_cell
);

    logic [ID_W-1:0] r_value;
    logic            r_valid;
    logic            r_eq;
    logic            w_gt;

    // Local compare against the broadcast ID
    assign w_gt = r_valid && (r_value > i_ctrl.id);

    // Valid bit: control state, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_ctrl.op)
                CELL_INS: begin
                    if (i_left.gt) begin
                        r_valid <= 1'b1;
                    end else if (i_left.valid && (w_gt || !r_valid)) begin
                        r_valid <= 1'b1;
                    end
                end
                CELL_SHL: r_valid <= i_right.valid;
                default:  r_valid <= r_valid;
            endcase
        end
    end

    // Entry value and match flag
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            CELL_CMP: r_eq <= r_valid && (r_value == i_ctrl.id);
            CELL_INS: begin
                if (i_left.gt) begin
                    r_value <= i_left.value;
                end else if (i_left.valid && (w_gt || !r_valid)) begin
                    r_value <= i_ctrl.id;
                end
            end
            CELL_SHL: r_value <= i_right.value;
            default:  r_value <= r_value;
        endcase
    end

    assign o_cell = '{value: r_value, valid: r_valid, gt: w_gt, eq: r_eq};

endmodule

>>> sv/reply_id_window_tracker.sv
// Sequence per transaction: accept, compare, insert, one shift per front
//   entry collapsed (0 to WINDOW_DEPTH-1), result; one transaction at a time.
// The next input is taken once the result is registered; the result step
//   waits while an earlier result waits for i_ready.
// Reset: synchronous, clears entry count, cell valid bits and handshakes;
//   no clearing pass, the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
// Reply ID window tracker
// Sorted window of received reply IDs held in a row of cells; reports the
// highest gap-free ID, entry count and ignore/overflow flags per transaction.
// ----------------------------------------------------------------------------
module reply_id_window_tracker
    import ridwt_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [ID_W-1:0]        i_reply_id,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [ID_W-1:0]        o_cumulative_id,
    output logic [COUNT_OUT_W-1:0] o_held_count,
    output logic                   o_was_ignored,
    output logic                   o_overflowed
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_INS,
        S_COL
    } t_state;

    t_state                r_state;
    logic [ID_W-1:0]       r_id;
    logic [CW-1:0]         r_count;
    logic                  r_ignored;
    logic                  r_over;
    logic                  r_out_valid;
    logic [ID_W-1:0]       r_out_cum;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic                  r_out_ign;
    logic                  r_out_ovf;

    t_cell_ctrl            w_ctrl;
    t_cell_out             w_cell [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] w_eq;
    logic                  w_held;
    logic                  w_ignore;
    logic                  w_over;
    logic                  w_ins;
    logic                  w_col;
    logic                  w_done;

    // Cell row
    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        t_cell_out w_left;
        t_cell_out w_right;
        if (g == 0) begin : g_head
            assign w_left = CELL_HEAD;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == WINDOW_DEPTH - 1) begin : g_tail
            assign w_right = CELL_NONE;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        assign w_eq[g] = w_cell[g].eq;

        ridwt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_cell  (w_cell[g])
        );
    end

    // Insert decision from registered match flags and the front entry
    assign w_held   = |w_eq;
    assign w_ignore = w_cell[0].valid && ((r_id <= w_cell[0].value) || w_held);
    assign w_over   = !w_ignore && w_cell[WINDOW_DEPTH-1].valid;
    assign w_ins    = !w_ignore && !w_over;

    // Front run collapse: second entry directly follows the first
    assign w_col  = w_cell[1].valid && (w_cell[1].value == w_cell[0].value + ID_W'(1));
    assign w_done = (r_state == S_COL) && !w_col && (!r_out_valid || i_ready);

    // Broadcast operation to the row
    always_comb begin
        w_ctrl.id = r_id;
        case (r_state)
            S_CMP:   w_ctrl.op = CELL_CMP;
            S_INS:   w_ctrl.op = w_ins ? CELL_INS : CELL_HOLD;
            S_COL:   w_ctrl.op = w_col ? CELL_SHL : CELL_HOLD;
            default: w_ctrl.op = CELL_HOLD;
        endcase
    end

    // Sequencer, entry count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // New result wins over the release of the old one
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_id    <= i_reply_id;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: r_state <= S_INS;
                S_INS: begin
                    r_ignored <= w_ignore;
                    r_over    <= w_over;
                    if (w_ins) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_COL;
                end
                S_COL: begin
                    if (w_col) begin
                        r_count <= r_count - CW'(1);
                    end else if (w_done) begin
                        r_out_cum   <= w_cell[0].valid ? w_cell[0].value : '0;
                        r_out_count <= COUNT_OUT_W'(r_count);
                        r_out_ign   <= r_ignored;
                        r_out_ovf   <= r_over;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_cumulative_id = r_out_cum;
    assign o_held_count    = r_out_count;
    assign o_was_ignored   = r_out_ign;
    assign o_overflowed    = r_out_ovf;

`ifndef NO_ASSERTIONS
    // Entry count agrees with the front cell's valid bit
    a_count_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == w_cell[0].valid)
        else $error("entry count disagrees with front cell");

    // Window stays strictly ascending at the front
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[1].valid |-> (w_cell[1].value > w_cell[0].value))
        else $error("window front out of order");

    // A result is never both ignored and overflowed
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_was_ignored && o_overflowed))
        else $error("ignored and overflow both set");

    // An accepted transaction blocks further input until done
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second transaction accepted while busy");

    // Count only moves during insert or collapse
    a_count_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_CMP) |=> $stable(r_count))
        else $error("entry count changed outside insert or collapse");
`endif

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Reply ID window tracker testbench
// Sends reply IDs through the valid/ready input channel and keeps its own
// sorted model of the window, which predicts the cumulative ID, the entry
// count and the ignore and overflow flags of each transaction. A checker
// compares every result against the oldest prediction. The run goes from an
// empty window through in-order and out-of-order traffic with collapses to a
// full window at the end, since a full window never drains.
// ----------------------------------------------------------------------------
module tb;
    import ridwt_pkg::*;

    localparam int DEPTH     = WINDOW_DEPTH_DEF;
    localparam int MAX_SHOWN = 10;
    localparam int TAIL_WAIT = 40;

    typedef struct packed {
        logic [ID_W-1:0]        cum_id;
        logic [COUNT_OUT_W-1:0] count;
        logic                   ignored;
        logic                   overflow;
    } t_window_status;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_valid    = 1'b0;
    logic                   i_ready    = 1'b0;
    logic [ID_W-1:0]        i_reply_id = '0;
    logic                   o_ready;
    logic                   o_valid;
    logic [ID_W-1:0]        o_cumulative_id;
    logic [COUNT_OUT_W-1:0] o_held_count;
    logic                   o_was_ignored;
    logic                   o_overflowed;

    // Model window: ascending IDs, front is the cumulative ID
    logic [ID_W-1:0] window_ids[$];
    t_window_status  pending_status[$];
    t_window_status  got_status;
    t_window_status  want_status;
    int              mismatch_count = 0;
    int              rx_hold        = 0;
    bit              idle_on        = 1'b1;

    reply_id_window_tracker #(
        .WINDOW_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_reply_id     (i_reply_id),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cumulative_id(o_cumulative_id),
        .o_held_count   (o_held_count),
        .o_was_ignored  (o_was_ignored),
        .o_overflowed   (o_overflowed)
    );

    always #5 i_clk = ~i_clk;

    // Fail if the run hangs
    initial begin
        #6000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [ID_W-1:0] window_front();
        return (window_ids.size() > 0) ? window_ids[0] : '0;
    endfunction

    // Apply one reply ID to the model window and return the expected status
    function automatic t_window_status predict_reply(input logic [ID_W-1:0] id);
        t_window_status st;
        bit             is_held;
        int             pos;
        st      = '0;
        is_held = 1'b0;
        foreach (window_ids[i])
            if (window_ids[i] == id) is_held = 1'b1;
        if (window_ids.size() > 0 && (id <= window_ids[0] || is_held)) begin
            st.ignored = 1'b1;
        end else if (window_ids.size() >= DEPTH) begin
            st.overflow = 1'b1;
        end else begin
            pos = window_ids.size();
            for (int i = 0; i < window_ids.size(); i++) begin
                if (window_ids[i] > id) begin
                    pos = i;
                    break;
                end
            end
            window_ids.insert(pos, id);
            // collapse the gap-free run at the front
            while (window_ids.size() >= 2 &&
                   ID_W'(window_ids[0] + 32'd1) == window_ids[1])
                window_ids.delete(0);
        end
        st.cum_id = window_front();
        st.count  = COUNT_OUT_W'(window_ids.size());
        return st;
    endfunction

    // Drive one reply ID and hold it until the transaction is accepted
    task automatic send_reply(input logic [ID_W-1:0] id);
        int             gap;
        t_window_status st;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_reply_id <= id;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        st = predict_reply(id);
        pending_status.insert(pending_status.size(), st);
    endtask

    task automatic note_mismatch(input string what, input t_window_status want,
                                 input t_window_status got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
            $display("mismatch (%s): exp cum=%08h cnt=%0d ign=%b ovf=%b",
                     what, want.cum_id, want.count, want.ignored, want.overflow);
            $display("    got cum=%08h cnt=%0d ign=%b ovf=%b",
                     got.cum_id, got.count, got.ignored, got.overflow);
        end
    endtask

    // Result side: random stall bursts, then check each accepted transaction
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(0, 16);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end

        if (i_rst_n && o_valid && i_ready) begin
            got_status.cum_id   = o_cumulative_id;
            got_status.count    = o_held_count;
            got_status.ignored  = o_was_ignored;
            got_status.overflow = o_overflowed;
            if (pending_status.size() == 0) begin
                note_mismatch("unexpected result", '0, got_status);
            end else begin
                want_status = pending_status[0];
                pending_status.delete(0);
                if (got_status.cum_id   !== want_status.cum_id  ||
                    got_status.count    !== want_status.count   ||
                    got_status.ignored  !== want_status.ignored ||
                    got_status.overflow !== want_status.overflow)
                    note_mismatch("field", want_status, got_status);
            end
        end
    end

    // Empty window, at-front, already-held and short collapse cases
    task automatic test_empty_and_order();
        send_reply(32'd0);   // empty window takes 0 as front
        send_reply(32'd0);   // equal to front
        send_reply(32'd2);
        send_reply(32'd2);   // already held
        send_reply(32'd1);   // fills gap, collapses to 2
        send_reply(32'd5);
        send_reply(32'd4);
        send_reply(32'd3);   // collapses to 5
        send_reply(32'd1);   // below front
    endtask

    // Build front+2..front+15 out of order, then front+1 collapses them all
    task automatic test_long_collapse();
        logic [ID_W-1:0] base;
        base = window_front();
        for (int i = 0; i < DEPTH - 2; i++)
            send_reply((i % 2) ? base + 32'd2 + ID_W'(i / 2)
                               : base + ID_W'(DEPTH - 1) - ID_W'(i / 2));
        send_reply(base + 32'd1);
    endtask

    // Mostly well-formed traffic near the front; count kept below full
    task automatic test_random_mix(input int n_items);
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] id;
        int              r;
        int              n;
        for (int k = 0; k < n_items; k++) begin
            base = window_front();
            n    = window_ids.size();
            r    = $urandom_range(0, 99);
            if (n >= DEPTH - 4 || r < 30)
                id = base + 32'd1;
            else if (r < 55)
                id = base + ID_W'($urandom_range(2, 6));
            else if (r < 75)
                id = base + ID_W'($urandom_range(2, 24));
            else if (r < 85)
                id = $urandom_range(0, base);
            else if (r < 95 && n > 1)
                id = window_ids[$urandom_range(1, n - 1)];
            else
                id = base + 32'd2;
            send_reply(id);
        end
    endtask

    // Fill the window; a full window drops every new ID from then on
    task automatic test_full_window(input int n_items);
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] id;
        int              r;
        base = window_front();
        for (int i = 1; window_ids.size() < DEPTH; i++)
            send_reply(base + ID_W'(2 * i));
        send_reply(base + 32'd1);     // would collapse, but dropped
        send_reply(32'hFFFF_FFFF);
        send_reply(base);             // equal to front
        send_reply(base + 32'd2);     // already held
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                id = $urandom();
            else if (r < 60)
                id = $urandom_range(0, base);
            else if (r < 80)
                id = window_ids[$urandom_range(0, DEPTH - 1)];
            else
                id = base + 32'd1;
            send_reply(id);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_order();
        test_long_collapse();
        test_random_mix(1200);
        // last part of the run without idle cycles
        idle_on = 1'b0;
        test_random_mix(300);
        test_full_window(100);

        i_valid <= 1'b0;
        while (pending_status.size() > 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
